>>> design/rgb_to_hsv_top_assert.svh
// Assertion macros shared by the queue and divider modules of the color conversion block.
`ifndef RGB_TO_HSV_TOP_ASSERT_SVH
`define RGB_TO_HSV_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RTH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTH_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RTH_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTH_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> design/rth_pkg.sv
package rth_pkg;

  localparam int COMPONENT_BITS = 8;
  localparam int QUO_BITS = 16;
  localparam int HUE_W = COMPONENT_BITS + 3;
  localparam int SAT_W = COMPONENT_BITS;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [QUO_BITS-1:0]       hue;
    logic [QUO_BITS-1:0]       saturation;
    logic [COMPONENT_BITS-1:0] value;
  } hsv_t;

  typedef struct packed {
    logic [HUE_W-1:0]          hue_rem;
    logic [HUE_W-1:0]          hue_div;
    logic [SAT_W-1:0]          sat_rem;
    logic [QUO_BITS-1:0]       sat_lo;
    logic [SAT_W-1:0]          sat_div;
    logic [COMPONENT_BITS-1:0] value;
  } work_t;

  function automatic logic [HUE_W:0] hue_step(logic [HUE_W-1:0] rem, logic [HUE_W-1:0] dvs);
    logic [HUE_W:0] sh;
    logic [HUE_W:0] df;
    sh = {rem, 1'b0};
    df = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {1'b1, df[HUE_W-1:0]};
    end
    return {1'b0, sh[HUE_W-1:0]};
  endfunction

  function automatic logic [SAT_W:0] sat_step(logic [SAT_W-1:0] rem, logic bit_in,
                                               logic [SAT_W-1:0] dvs);
    logic [SAT_W:0] sh;
    logic [SAT_W:0] df;
    sh = {rem, bit_in};
    df = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {1'b1, df[SAT_W-1:0]};
    end
    return {1'b0, sh[SAT_W-1:0]};
  endfunction

endpackage

>>> design/rgb_to_hsv_top.sv
// RGB to HSV color conversion.
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one pixel per
// transaction as red, green and blue components. The output channel
// (out_valid_o, out_ready_i, out_data_o) gives hue, saturation and value.
// A front stage finds the largest and smallest component, the hue sector and
// the dividends and divisors, and hands its work to a small queue.
// The back part runs both divisions through a 16 stage pipeline that retires
// one quotient bit per stage for hue and saturation side by side.
// Without stalls one pixel is taken and one result given every cycle.
// When the receiver stalls, the divider pipeline holds in place, the queue
// fills, and in_ready_o falls once the queue and front stage are full.
// Reset empties the front stage, the queue and the pipeline; no results are
// pending afterward and the block is ready in the first cycle.
module rgb_to_hsv_top
  import rth_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output hsv_t   out_data_o
);

  logic  push;
  logic  push_ready;
  work_t push_data;
  logic  pop_valid;
  logic  pop;
  work_t pop_data;

  rth_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .work_o       (push_data)
  );

  rth_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  rth_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (pop_valid),
    .pop_o        (pop),
    .work_i       (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> design/rth_front.sv
module rth_front
  import rth_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_data_i,
  output logic   push_o,
  input  logic   push_ready_i,
  output work_t  work_o
);

  localparam int C = COMPONENT_BITS;

  logic  valid_q;
  work_t work_q;
  work_t work_d;

  logic [C-1:0]    r, g, b, hi, lo, diff;
  logic [C+2:0]    d6;
  logic [C+3:0]    num;
  logic [C+3:0]    num_fix;
  logic [C+15:0]   satn;

  always_comb begin
    r = in_data_i.red;
    g = in_data_i.green;
    b = in_data_i.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    diff = hi - lo;
    d6 = {1'b0, diff, 2'b00} + {2'b00, diff, 1'b0};
    if (r == hi) begin
      num = {4'b0000, g} - {4'b0000, b};
    end else if (g == hi) begin
      num = {3'b000, diff, 1'b0} + {4'b0000, b} - {4'b0000, r};
    end else begin
      num = {2'b00, diff, 2'b00} + {4'b0000, r} - {4'b0000, g};
    end
    num_fix = num[C+3] ? (num + {1'b0, d6}) : num;
    satn = {diff, 16'h0000} - {16'h0000, diff};
    work_d.hue_rem = num_fix[C+2:0];
    work_d.hue_div = (diff == '0) ? HUE_W'(1) : d6;
    work_d.sat_rem = satn[C+15:16];
    work_d.sat_lo  = satn[15:0];
    work_d.sat_div = (hi == '0) ? SAT_W'(1) : hi;
    work_d.value   = hi;
  end

  assign push_o     = valid_q && push_ready_i;
  assign in_ready_o = !valid_q || push_ready_i;
  assign work_o     = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

>>> design/rth_fifo.sv
`include "rgb_to_hsv_top_assert.svh"

module rth_fifo
  import rth_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  push_ready_o,
  input  work_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output work_t pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `RTH_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "Queue count exceeds depth.")
  `RTH_ASSERT_IMPL(a_count_inc, clk_i, rst_ni, push_i && !pop_i, count_q == CW'($past(count_q) + 1'b1), "Queue count did not grow on push.")
  `RTH_ASSERT(a_pop_nonempty, clk_i, rst_ni, !pop_i || (count_q != '0), "Pop from an empty queue.")

endmodule

>>> design/rth_back.sv
`include "rgb_to_hsv_top_assert.svh"

module rth_back
  import rth_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  work_valid_i,
  output logic  pop_o,
  input  work_t work_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output hsv_t  out_data_o
);

  localparam int NS = QUO_BITS;

  typedef struct packed {
    logic [HUE_W-1:0]          hue_rem;
    logic [HUE_W-1:0]          hue_div;
    logic [QUO_BITS-1:0]       hue_q;
    logic [SAT_W-1:0]          sat_rem;
    logic [QUO_BITS-1:0]       sat_lo;
    logic [SAT_W-1:0]          sat_div;
    logic [QUO_BITS-1:0]       sat_q;
    logic [COMPONENT_BITS-1:0] value;
  } stage_t;

  logic   [NS:0] vld_q;
  stage_t        st_q [NS+1];
  logic          adv;

  assign adv   = !vld_q[NS] || out_ready_i;
  assign pop_o = work_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-1:0], work_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].hue_rem <= work_i.hue_rem;
      st_q[0].hue_div <= work_i.hue_div;
      st_q[0].hue_q   <= '0;
      st_q[0].sat_rem <= work_i.sat_rem;
      st_q[0].sat_lo  <= work_i.sat_lo;
      st_q[0].sat_div <= work_i.sat_div;
      st_q[0].sat_q   <= '0;
      st_q[0].value   <= work_i.value;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [HUE_W:0] hue_res;
    logic [SAT_W:0] sat_res;

    assign hue_res = hue_step(st_q[k].hue_rem, st_q[k].hue_div);
    assign sat_res = sat_step(st_q[k].sat_rem, st_q[k].sat_lo[QUO_BITS-1], st_q[k].sat_div);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k+1].hue_rem <= hue_res[HUE_W-1:0];
        st_q[k+1].hue_div <= st_q[k].hue_div;
        st_q[k+1].hue_q   <= {st_q[k].hue_q[QUO_BITS-2:0], hue_res[HUE_W]};
        st_q[k+1].sat_rem <= sat_res[SAT_W-1:0];
        st_q[k+1].sat_lo  <= {st_q[k].sat_lo[QUO_BITS-2:0], 1'b0};
        st_q[k+1].sat_div <= st_q[k].sat_div;
        st_q[k+1].sat_q   <= {st_q[k].sat_q[QUO_BITS-2:0], sat_res[SAT_W]};
        st_q[k+1].value   <= st_q[k].value;
      end
    end
  end

  assign out_valid_o           = vld_q[NS];
  assign out_data_o.hue        = st_q[NS].hue_q;
  assign out_data_o.saturation = st_q[NS].sat_q;
  assign out_data_o.value      = st_q[NS].value;

  `RTH_ASSERT(a_hue_rem, clk_i, rst_ni, !vld_q[NS] || (st_q[NS].hue_rem < st_q[NS].hue_div), "Hue remainder not below divisor.")
  `RTH_ASSERT(a_sat_rem, clk_i, rst_ni, !vld_q[NS] || (st_q[NS].sat_rem < st_q[NS].sat_div), "Saturation remainder not below divisor.")

endmodule

>>> bench/tb_rgb_to_hsv_top.sv
`timescale 1ns / 100ps

module tb_rgb_to_hsv_top
  import rth_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  pixel_t in_data   = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  hsv_t   out_data;

  hsv_t pending_hsv_q[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   src_idle_on = 1'b1;
  bit   snk_idle_on = 1'b1;
  int   sink_hold_cycles = 0;

  rgb_to_hsv_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic hsv_t convert_pixel(input pixel_t px);
    int   r;
    int   g;
    int   b;
    int   hi;
    int   lo;
    int   span;
    int   num;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    res = '0;
    res.value = hi[COMPONENT_BITS-1:0];
    if (hi != 0) begin
      res.saturation = 16'((65535 * span) / hi);
    end
    if (span != 0) begin
      if (r == hi) begin
        num = g - b;
      end else if (g == hi) begin
        num = 2 * span + b - r;
      end else begin
        num = 4 * span + r - g;
      end
      if (num < 0) begin
        num += 6 * span;
      end
      res.hue = 16'((longint'(num) * 65536) / (6 * span));
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    int     v;
    int     w;
    pixel_t px;
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom_range(0, 255);
        px = {v[7:0], v[7:0], v[7:0]};
      end
      1: begin
        v = $urandom_range(1, 255);
        w = $urandom_range(0, v - 1);
        case ($urandom_range(0, 2))
          0: px = {v[7:0], v[7:0], w[7:0]};
          1: px = {v[7:0], w[7:0], v[7:0]};
          default: px = {w[7:0], v[7:0], v[7:0]};
        endcase
      end
      2: begin
        px.red   = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        px.green = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        px.blue  = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      end
      default: begin
        v = $urandom;
        px = v[23:0];
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    pending_hsv_q.push_back(convert_pixel(px));
  endtask

  task automatic report_mismatch(input string what, input hsv_t want, input hsv_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected hue %0d sat %0d value %0d, got hue %0d sat %0d value %0d",
               what, want.hue, want.saturation, want.value,
               got.hue, got.saturation, got.value);
    end
  endtask

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hsv_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, out_data);
      end else begin
        want = pending_hsv_q.pop_front();
        if (out_data.hue != want.hue || out_data.saturation != want.saturation ||
            out_data.value != want.value) begin
          report_mismatch("mismatch", want, out_data);
        end
      end
    end
  end

  initial begin
    int gap;
    int hold;
    forever begin
      if (sink_hold_cycles > 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
        repeat (hold) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
      end
      gap = snk_idle_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic test_directed();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128});
    send_pixel({8'd1, 8'd1, 8'd1});
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd200, 8'd200, 8'd200 - 8'd1});
    send_pixel({8'd255, 8'd0, 8'd10});
    send_pixel({8'd255, 8'd10, 8'd0});
    send_pixel({8'd1, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd1});
    send_pixel({8'd0, 8'd1, 8'd0});
    send_pixel({8'd255, 8'd254, 8'd254});
    send_pixel({8'd254, 8'd255, 8'd255});
    send_pixel({8'd10, 8'd200, 8'd30});
    send_pixel({8'd30, 8'd200, 8'd10});
    send_pixel({8'd30, 8'd20, 8'd250});
    send_pixel({8'd20, 8'd30, 8'd250});
    send_pixel({8'haa, 8'h55, 8'hff});
  endtask

  task automatic test_random();
    for (int chunk = 0; chunk < 15; chunk++) begin
      src_idle_on = $urandom_range(0, 1);
      snk_idle_on = $urandom_range(0, 1);
      repeat (40) send_pixel(random_pixel());
    end
  endtask

  task automatic test_back_to_back();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (60) send_pixel(random_pixel());
  endtask

  task automatic test_backpressure();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    sink_hold_cycles = 250;
    repeat (80) send_pixel(random_pixel());
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random();
    test_back_to_back();
    test_backpressure();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_hsv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_hsv_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
